>>> sv/afe_pkg.sv
package afe_pkg;

	localparam logic [2:0] HEADER_MARK  = 3'b111;
	localparam logic [4:0] BRIGHT_RESET = 5'd15;
	localparam logic [7:0] START_BYTE   = 8'h00;
	localparam logic [7:0] END_BYTE     = 8'hFF;
	localparam logic [8:0] W_FULL       = 9'd256;
	localparam logic [1:0] FRAME_LAST   = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	typedef struct packed {
		color_t color;
		logic   first;
		logic   last;
	} led_item_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_HDR,
		PH_BLUE,
		PH_GREEN,
		PH_RED,
		PH_END
	} phase_t;

	// prev + floor((tgt - prev) * w / 256)
	function automatic logic [7:0] blend_ch(input logic [7:0] prev, input logic [7:0] tgt,
			input logic [8:0] w);
		logic signed [9:0]  d;
		logic signed [19:0] prod;
		logic signed [9:0]  step;
		logic [9:0]         sum;
		d    = signed'({2'b00, tgt}) - signed'({2'b00, prev});
		prod = 20'(d) * 20'(signed'({1'b0, w}));
		step = prod[17:8];
		sum  = {2'b00, prev} + $unsigned(step);
		return sum[7:0];
	endfunction

endpackage

>>> sv/afe_ram.sv
module afe_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/afe_blend.sv
module afe_blend
	import afe_pkg::*;
(
	input  color_t     prev,
	input  color_t     tgt,
	input  logic [8:0] weight,
	output color_t     blended
);

	always_comb begin
		blended.red   = blend_ch(prev.red, tgt.red, weight);
		blended.green = blend_ch(prev.green, tgt.green, weight);
		blended.blue  = blend_ch(prev.blue, tgt.blue, weight);
	end

endmodule

>>> sv/afe_emit.sv
module afe_emit
	import afe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  led_item_t item,
	input  logic [4:0] brightness,
	input  logic      out_ready,
	output logic      out_valid,
	output logic [7:0] spi_byte,
	output logic      last_of_run,
	output logic      frame_end,
	output logic      done,
	output color_t    held_color
);

	phase_t    phase_q, phase_d;
	logic [1:0] sub_q, sub_d;
	logic      valid_q;
	led_item_t item_q;
	logic      fin;
	logic      take;

	always_comb begin
		phase_d   = phase_q;
		sub_d     = 2'd0;
		fin       = 1'b0;
		frame_end = 1'b0;
		spi_byte  = START_BYTE;
		case (phase_q)
			PH_START: begin
				spi_byte = START_BYTE;
				sub_d    = sub_q + 2'd1;
				if (sub_q == FRAME_LAST) begin
					phase_d = PH_HDR;
				end
			end
			PH_HDR: begin
				spi_byte = {HEADER_MARK, brightness};
				phase_d  = PH_BLUE;
			end
			PH_BLUE: begin
				spi_byte = item_q.color.blue;
				phase_d  = PH_GREEN;
			end
			PH_GREEN: begin
				spi_byte = item_q.color.green;
				phase_d  = PH_RED;
			end
			PH_RED: begin
				spi_byte = item_q.color.red;
				fin      = !item_q.last;
				phase_d  = PH_END;
			end
			PH_END: begin
				spi_byte  = END_BYTE;
				sub_d     = sub_q + 2'd1;
				fin       = (sub_q == FRAME_LAST);
				frame_end = fin;
			end
			default: begin
				spi_byte = START_BYTE;
				phase_d  = PH_HDR;
			end
		endcase
	end

	assign take        = valid_q && out_ready;
	assign done        = take && fin;
	assign out_valid   = valid_q;
	assign last_of_run = fin;
	assign held_color  = item_q.color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= PH_HDR;
			sub_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= item.first ? PH_START : PH_HDR;
			sub_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

endmodule

>>> sv/apa102_fading_frame_emitter_unit.sv
// APA102 fading frame emitter.
// Input channel (in_valid/in_ready): one LED per item, target color plus a
// Q1.8 fade weight (values above 256 act as 256). Items map to LEDs in order,
// 0 .. LED_COUNT-1, then wrap to a new frame.
// Output channel (out_valid/out_ready): one byte per item on spi_byte.
// Each LED gives header, blue, green, red; the first LED of a frame is led by
// four 0x00 bytes, the last is followed by four 0xFF bytes. last_of_run marks
// the final byte of an LED, frame_end the final byte of a frame.
// cfg_we/cfg_wdata write the 5-bit global brightness (reset 15).
// Path: an accepted item is registered in stage 1 together with its color
// memory read; the blend feeds the output register once that is free.
// The byte-wide output port sets the pace; the next item is read and blended
// while the current one is still shifting out.
// Reset: position returns to LED 0 and all stored colors read as black until
// the first frame has been written; no clearing pass is needed.
// A stalled receiver holds the current byte; at most two items stay in flight.
module apa102_fading_frame_emitter_unit
	import afe_pkg::*;
#(
	parameter int LED_COUNT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] target_red,
	input  logic [7:0] target_green,
	input  logic [7:0] target_blue,
	input  logic [8:0] lerp_weight,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] spi_byte,
	output logic       last_of_run,
	output logic       frame_end
);

	localparam int POS_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LED_COUNT - 1);

	logic [4:0]       bright_q;
	logic [POS_W-1:0] pos_q;
	logic             wrapped_q;

	logic             acc;
	logic             s1_adv;
	logic             emit_done;
	logic             pos_first;
	logic             pos_last;

	logic             valid_s1;
	color_t           tgt_s1;
	logic [8:0]       wt_s1;
	logic             first_s1;
	logic             last_s1;
	logic [POS_W-1:0] addr_s1;
	logic             fwd_s1;
	logic             zero_s1;

	color_t           rd_color;
	color_t           held_color;
	color_t           prev_color;
	color_t           new_color;
	led_item_t        s1_item;

	assign pos_first = (pos_q == '0);
	assign pos_last  = (pos_q == POS_LAST);
	assign s1_adv    = valid_s1 && (!out_valid || emit_done);
	assign in_ready  = !valid_s1 || s1_adv;
	assign acc       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
		end else if (cfg_we) begin
			bright_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= pos_last ? '0 : pos_q + POS_W'(1);
				if (pos_last) begin
					wrapped_q <= 1'b1;
				end
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tgt_s1   <= '{red: target_red, green: target_green, blue: target_blue};
			wt_s1    <= (lerp_weight > W_FULL) ? W_FULL : lerp_weight;
			first_s1 <= pos_first;
			last_s1  <= pos_last;
			addr_s1  <= pos_q;
			// previous item writes this entry in the same cycle as the read
			fwd_s1   <= valid_s1 && s1_adv && (addr_s1 == pos_q);
			zero_s1  <= !wrapped_q;
		end
	end

	afe_ram #(
		.WIDTH ($bits(color_t)),
		.DEPTH (LED_COUNT),
		.ADDR_W(POS_W)
	) u_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(addr_s1),
		.wdata(new_color),
		.re   (acc),
		.raddr(pos_q),
		.rdata(rd_color)
	);

	always_comb begin
		if (fwd_s1) begin
			prev_color = held_color;
		end else if (zero_s1) begin
			prev_color = '0;
		end else begin
			prev_color = rd_color;
		end
	end

	afe_blend u_blend (
		.prev   (prev_color),
		.tgt    (tgt_s1),
		.weight (wt_s1),
		.blended(new_color)
	);

	assign s1_item = '{color: new_color, first: first_s1, last: last_s1};

	afe_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv),
		.item       (s1_item),
		.brightness (bright_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.spi_byte   (spi_byte),
		.last_of_run(last_of_run),
		.frame_end  (frame_end),
		.done       (emit_done),
		.held_color (held_color)
	);

`ifndef NO_ASSERTIONS
	a_fend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_run)
		else $error("frame_end without last_of_run");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_last |=> pos_q == '0)
		else $error("position did not wrap after last LED");

	a_fwd_collision: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s1_adv && (addr_s1 == pos_q) |=> fwd_s1)
		else $error("same-entry read/write not forwarded");

	a_fwd_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> LED_COUNT == 1)
		else $error("forwarding with more than one LED");
`endif

endmodule
